### design/smcf_pkg.sv
package smcf_pkg;

  localparam int unsigned WINDOW_MAX_DEF   = 9;
  localparam int unsigned ECHO_DIVISOR_DEF = 58;
  localparam int unsigned SERVO_CENTER_DEF = 1500;
  localparam int unsigned SERVO_STEP_DEF   = 10;

  localparam int unsigned ECHO_W   = 16;
  localparam int unsigned SERVO_W  = 16;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned DIST_W   = 10;
  localparam int unsigned TOL_W    = 4;
  localparam int unsigned FSIZE_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // reciprocal scaling for the constant dividers
  localparam int unsigned RECIP_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE  = 2'd2;

  localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST = 10'd400;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST    = 4'd1;
  localparam logic [FSIZE_W-1:0] FILTER_SIZE_RST  = 4'd5;

  localparam logic [ANGLE_W-1:0] ANGLE_POS_SAT = 8'h7f;
  localparam logic [ANGLE_W-1:0] ANGLE_NEG_SAT = 8'h80;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic fix;
    logic rank;
    logic out_load;
  } smcf_cmd_t;

  typedef struct packed {
    logic take_echo;
    logic fill_ok;
    logic rank_last;
    logic report;
    logic out_busy;
  } smcf_sts_t;

endpackage

### design/sonar_median_change_filter.sv
// sonar median change filter
// input channel (in_valid/in_ready): in_op 0 carries an echo length and the
// servo compare value; in_op 1 clears the last reported vector. an echo of 0
// is accepted and dropped. each echo becomes a distance (echo / ECHO_DIVISOR,
// clamped to max_distance) and an angle ((compare - SERVO_CENTER) /
// SERVO_STEP, saturated to 8 bits) and goes into a ring of filter_size
// entries. once the ring is full the median entry is reported on the output
// channel (out_valid/out_ready) if its angle changed or its distance moved
// by more than tolerance.
// each echo goes through accept, two multiply steps (MUL1, MUL2), one
// correction and ring write step, a rank walk over the filter_size entries
// at one candidate per cycle, and one check step. the next echo is taken
// only once the controller is back in idle; an echo that does not yet fill
// the ring returns to idle after the ring write. clear and empty
// transactions are handled in the accept step alone.
// the output is registered; a finished result waits there while the next
// transaction is taken, and a new result stalls in the check cycle until the
// register is free. the user must write configuration (cfg_we, cfg_index,
// cfg_wdata) only while idle; the block itself does not enforce this. reset
// restores the register defaults and empties the ring.
module sonar_median_change_filter
  import smcf_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int unsigned ECHO_DIVISOR = ECHO_DIVISOR_DEF,
  parameter int unsigned SERVO_CENTER = SERVO_CENTER_DEF,
  parameter int unsigned SERVO_STEP   = SERVO_STEP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [ECHO_W-1:0]     in_echo_usec,
  input  logic [SERVO_W-1:0]    in_servo_compare,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANGLE_W-1:0]    out_servo_angle,
  output logic [DIST_W-1:0]     out_distance_cm
);

  smcf_cmd_t cmd;
  smcf_sts_t sts;

  smcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smcf_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .ECHO_DIVISOR (ECHO_DIVISOR),
    .SERVO_CENTER (SERVO_CENTER),
    .SERVO_STEP   (SERVO_STEP)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_op            (in_op),
    .in_echo_usec     (in_echo_usec),
    .in_servo_compare (in_servo_compare),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_servo_angle  (out_servo_angle),
    .out_distance_cm  (out_distance_cm),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

### design/smcf_ctrl.sv
module smcf_ctrl
  import smcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  smcf_sts_t sts,
  output smcf_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_MUL2  = 3'd2;
  localparam logic [2:0] ST_FIX   = 3'd3;
  localparam logic [2:0] ST_RANK  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.take_echo) state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = sts.fill_ok ? ST_RANK : ST_IDLE;
      end
      ST_RANK: begin
        cmd.rank = 1'b1;
        if (sts.rank_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.report) begin
          state_nxt = ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/smcf_dp.sv
module smcf_dp
  import smcf_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int unsigned ECHO_DIVISOR = ECHO_DIVISOR_DEF,
  parameter int unsigned SERVO_CENTER = SERVO_CENTER_DEF,
  parameter int unsigned SERVO_STEP   = SERVO_STEP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_op,
  input  logic [ECHO_W-1:0]     in_echo_usec,
  input  logic [SERVO_W-1:0]    in_servo_compare,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANGLE_W-1:0]    out_servo_angle,
  output logic [DIST_W-1:0]     out_distance_cm,
  input  smcf_cmd_t             cmd,
  output smcf_sts_t             sts
);

  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned REC_E = (1 << RECIP_SHIFT) / ECHO_DIVISOR;
  localparam int unsigned REC_A = (1 << RECIP_SHIFT) / SERVO_STEP;
  localparam int unsigned PROD_W = ECHO_W + RECIP_SHIFT + 1;
  localparam int unsigned QD_W   = 24;
  localparam int unsigned QA_W   = 26;
  localparam int unsigned DIFF_W = SERVO_W + 2;

  localparam logic [CNT_W-1:0]   WIN_MAX_C = CNT_W'(WINDOW_MAX);
  localparam logic [FSIZE_W-1:0] FS_RST    =
    (WINDOW_MAX < 5) ? FSIZE_W'(WINDOW_MAX) : FILTER_SIZE_RST;

  // configuration
  logic [DIST_W-1:0]  max_dist_r;
  logic [TOL_W-1:0]   tol_r;
  logic [FSIZE_W-1:0] fsize_r;
  logic [FSIZE_W-1:0] fsize_wr;
  logic [CNT_W-1:0]   fs_c;

  // captured transaction
  logic [ECHO_W-1:0]  echo_r;
  logic [SERVO_W-1:0] mag_r;
  logic               neg_r;
  logic [DIFF_W-1:0]  sdiff;
  logic [DIFF_W-1:0]  smag;

  // divider stages
  logic [PROD_W-1:0]  prod_e;
  logic [PROD_W-1:0]  prod_a;
  logic [ECHO_W-1:0]  qe_est_r;
  logic [SERVO_W-1:0] qa_est_r;
  logic [QD_W-1:0]    qd_r;
  logic [QA_W-1:0]    qas_r;
  logic [QD_W-1:0]    rem_e;
  logic [QA_W-1:0]    rem_a;
  logic [ECHO_W:0]    qe;
  logic [SERVO_W:0]   qa;
  logic [DIST_W-1:0]  new_dist;
  logic [ANGLE_W-1:0] new_angle;

  // window
  logic [ANGLE_W-1:0] win_a_r [WINDOW_MAX];
  logic [DIST_W-1:0]  win_d_r [WINDOW_MAX];
  logic [IDX_W-1:0]   wp_r;
  logic [CNT_W-1:0]   fill_r;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_inc;
  logic [CNT_W-1:0]   fill_inc;

  // rank walk
  logic [IDX_W-1:0]   i_r;
  logic [DIST_W-1:0]  cand;
  logic [CNT_W-1:0]   rank;
  logic [ANGLE_W-1:0] sel_a_r;
  logic [DIST_W-1:0]  sel_d_r;

  // last report and output
  logic [ANGLE_W-1:0] last_a_r;
  logic [DIST_W-1:0]  last_d_r;
  logic [DIST_W-1:0]  dist_gap;
  logic               out_valid_r;
  logic [ANGLE_W-1:0] out_a_r;
  logic [DIST_W-1:0]  out_d_r;

  assign fs_c = fsize_r[CNT_W-1:0];

  always_comb begin
    if (cfg_wdata[FSIZE_W-1:0] == '0) begin
      fsize_wr = FSIZE_W'(1);
    end else if (cfg_wdata[FSIZE_W-1:0] > FSIZE_W'(WINDOW_MAX)) begin
      fsize_wr = FSIZE_W'(WINDOW_MAX);
    end else begin
      fsize_wr = cfg_wdata[FSIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= MAX_DISTANCE_RST;
      tol_r      <= TOLERANCE_RST;
      fsize_r    <= FS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DISTANCE: max_dist_r <= cfg_wdata[DIST_W-1:0];
        REG_TOLERANCE:    tol_r      <= cfg_wdata[TOL_W-1:0];
        REG_FILTER_SIZE:  fsize_r    <= fsize_wr;
        default: ;
      endcase
    end
  end

  // servo offset magnitude and sign
  assign sdiff = DIFF_W'(in_servo_compare) - DIFF_W'(SERVO_CENTER);
  assign smag  = sdiff[DIFF_W-1] ? (DIFF_W'(0) - sdiff) : sdiff;

  assign sts.take_echo = !in_op && (in_echo_usec != '0);

  // reciprocal multiply, then one correction step
  assign prod_e = PROD_W'(echo_r) * PROD_W'(REC_E);
  assign prod_a = PROD_W'(mag_r) * PROD_W'(REC_A);
  assign rem_e  = QD_W'(echo_r) - qd_r;
  assign rem_a  = QA_W'(mag_r) - qas_r;
  assign qe     = (ECHO_W+1)'(qe_est_r) + (ECHO_W+1)'(rem_e >= QD_W'(ECHO_DIVISOR));
  assign qa     = (SERVO_W+1)'(qa_est_r) + (SERVO_W+1)'(rem_a >= QA_W'(SERVO_STEP));

  assign new_dist = (qe > (ECHO_W+1)'(max_dist_r)) ? max_dist_r : qe[DIST_W-1:0];

  always_comb begin
    if (neg_r) begin
      if (qa > (SERVO_W+1)'(ANGLE_NEG_SAT)) new_angle = ANGLE_NEG_SAT;
      else new_angle = ANGLE_W'((SERVO_W+1)'(0) - qa);
    end else begin
      if (qa > (SERVO_W+1)'(ANGLE_POS_SAT)) new_angle = ANGLE_POS_SAT;
      else new_angle = qa[ANGLE_W-1:0];
    end
  end

  // ring write position
  assign pos      = (CNT_W'(wp_r) >= fs_c) ? '0 : wp_r;
  assign pos_inc  = CNT_W'(pos) + CNT_W'(1);
  assign fill_inc = (fill_r == WIN_MAX_C) ? fill_r : fill_r + CNT_W'(1);
  assign sts.fill_ok = (fill_inc >= fs_c);

  // stable rank of the candidate entry
  assign cand = win_d_r[i_r];
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_MAX; j++) begin
      if ((CNT_W'(j) < fs_c) &&
          ((win_d_r[j] < cand) || ((win_d_r[j] == cand) && (IDX_W'(j) < i_r)))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end
  assign sts.rank_last = ((CNT_W'(i_r) + CNT_W'(1)) == fs_c);

  assign dist_gap   = (sel_d_r > last_d_r) ? (sel_d_r - last_d_r) : (last_d_r - sel_d_r);
  assign sts.report = (sel_a_r != last_a_r) || (dist_gap > DIST_W'(tol_r));
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      echo_r <= in_echo_usec;
      mag_r  <= smag[SERVO_W-1:0];
      neg_r  <= sdiff[DIFF_W-1];
    end
    if (cmd.mul1) begin
      qe_est_r <= prod_e[RECIP_SHIFT +: ECHO_W];
      qa_est_r <= prod_a[RECIP_SHIFT +: SERVO_W];
    end
    if (cmd.mul2) begin
      qd_r  <= QD_W'(qe_est_r) * QD_W'(ECHO_DIVISOR);
      qas_r <= QA_W'(qa_est_r) * QA_W'(SERVO_STEP);
    end
    if (cmd.fix) begin
      win_a_r[pos] <= new_angle;
      win_d_r[pos] <= new_dist;
    end
    if (cmd.rank && (rank == (fs_c >> 1))) begin
      sel_a_r <= win_a_r[i_r];
      sel_d_r <= cand;
    end
    if (cmd.out_load) begin
      out_a_r <= sel_a_r;
      out_d_r <= sel_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      i_r         <= '0;
      last_a_r    <= '0;
      last_d_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fix) begin
        wp_r   <= (pos_inc >= fs_c) ? '0 : pos_inc[IDX_W-1:0];
        fill_r <= fill_inc;
        i_r    <= '0;
      end else if (cmd.rank) begin
        i_r <= i_r + IDX_W'(1);
      end
      if (cmd.accept && in_op) begin
        last_a_r <= '0;
        last_d_r <= '0;
      end else if (cmd.out_load) begin
        last_a_r <= sel_a_r;
        last_d_r <= sel_d_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_servo_angle = out_a_r;
  assign out_distance_cm = out_d_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_MAX_C)
    else $error("fill count beyond window");

  a_rank_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rank |-> (CNT_W'(i_r) < fs_c))
    else $error("rank walk beyond window");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("output overwritten while stalled");

  a_last_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (last_a_r == out_a_r) && (last_d_r == out_d_r) && out_valid_r)
    else $error("last report differs from issued transaction");
`endif

endmodule
